>>> rtl/core/ppw_pkg.sv
// Shared types and constants for the projective pixel warp.
`timescale 1ns / 1ps
`default_nettype none
package ppw_pkg;
  localparam int SUM_W = 50;
  localparam int COEF_W = 32;
  localparam int OFFS_W = 48;
  localparam int DIM_W = 13;
  localparam int COORD_W = 12;
  localparam int ADDR_W = 6;

  // register byte addresses
  localparam logic [ADDR_W-1:0] REG_ROW0_LIN = 6'd0;
  localparam logic [ADDR_W-1:0] REG_ROW0_OFF = 6'd8;
  localparam logic [ADDR_W-1:0] REG_ROW1_LIN = 6'd16;
  localparam logic [ADDR_W-1:0] REG_ROW1_OFF = 6'd24;
  localparam logic [ADDR_W-1:0] REG_ROW2_LIN = 6'd32;
  localparam logic [ADDR_W-1:0] REG_ROW2_OFF = 6'd40;
  localparam logic [ADDR_W-1:0] REG_CANVAS_W = 6'd48;
  localparam logic [ADDR_W-1:0] REG_CANVAS_H = 6'd56;

  // dividend and divisor state handed along the divider chain
  typedef struct packed {
    logic              vld;
    logic              neg;      // quotient sign
    logic [SUM_W-1:0]  rem;      // partial remainder
    logic [SUM_W-1:0]  quo;      // dividend shifting out / quotient shifting in
  } div_lane_t;

  typedef struct packed {
    logic [SUM_W-1:0]  dmag;     // |W|
    logic              wz;       // W is zero
    logic [DIM_W-1:0]  cw;
    logic [DIM_W-1:0]  ch;
  } div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/ppw_div_cell.sv
// One restoring-division step cell: one quotient bit for X and Y lanes.
`timescale 1ns / 1ps
`default_nettype none
module ppw_div_cell #(
  parameter int PIX_W = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  ppw_pkg::div_lane_t  x_i,
  input  ppw_pkg::div_lane_t  y_i,
  input  ppw_pkg::div_ctl_t   ctl_i,
  input  wire  [PIX_W-1:0]    pix_i,
  output ppw_pkg::div_lane_t  x_o,
  output ppw_pkg::div_lane_t  y_o,
  output ppw_pkg::div_ctl_t   ctl_o,
  output logic [PIX_W-1:0]    pix_o
);
  localparam int W = ppw_pkg::SUM_W;
  ppw_pkg::div_lane_t x_r, y_r, x_nxt, y_nxt;
  ppw_pkg::div_ctl_t  ctl_r;
  logic [PIX_W-1:0]   pix_r;

  function automatic ppw_pkg::div_lane_t step(ppw_pkg::div_lane_t a, logic [W-1:0] d);
    ppw_pkg::div_lane_t r;
    logic [W:0] t;
    r = a;
    t = {a.rem, a.quo[W-1]};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      r.quo = {a.quo[W-2:0], 1'b1};
    end else begin
      r.quo = {a.quo[W-2:0], 1'b0};
    end
    r.rem = t[W-1:0];
    return r;
  endfunction

  // one shift-subtract step per cell
  always_comb begin
    x_nxt = step(x_i, ctl_i.dmag);
    y_nxt = step(y_i, ctl_i.dmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r.vld <= 1'b0;
    end else if (adv) begin
      x_r.vld <= x_i.vld;
    end
    if (adv) begin
      x_r.neg <= x_nxt.neg; x_r.rem <= x_nxt.rem; x_r.quo <= x_nxt.quo;
      y_r <= y_nxt;
      ctl_r <= ctl_i;
      pix_r <= pix_i;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign ctl_o = ctl_r;
  assign pix_o = pix_r;
endmodule
`default_nettype wire

>>> rtl/core/ppw_row_eval.sv
// Row evaluation: products, then sums, for the three matrix rows.
`timescale 1ns / 1ps
`default_nettype none
module ppw_row_eval (
  input  wire                          clk,
  input  wire                          adv,
  input  wire  [63:0]                  lin0,
  input  wire  [63:0]                  lin1,
  input  wire  [63:0]                  lin2,
  input  wire  [ppw_pkg::OFFS_W-1:0]   off0,
  input  wire  [ppw_pkg::OFFS_W-1:0]   off1,
  input  wire  [ppw_pkg::OFFS_W-1:0]   off2,
  input  wire  [ppw_pkg::COORD_W-1:0]  x,
  input  wire  [ppw_pkg::COORD_W-1:0]  y,
  output logic signed [ppw_pkg::SUM_W-1:0] sx,
  output logic signed [ppw_pkg::SUM_W-1:0] sy,
  output logic signed [ppw_pkg::SUM_W-1:0] sw
);
  localparam int W = ppw_pkg::SUM_W;
  localparam int P = ppw_pkg::COEF_W + ppw_pkg::COORD_W + 1;
  logic signed [P-1:0] p_r [6];
  logic signed [W-1:0] o_r [3];
  logic signed [ppw_pkg::COORD_W:0] xs, ys;
  logic [63:0] lin [3];
  logic [ppw_pkg::OFFS_W-1:0] off [3];

  assign xs = $signed({1'b0, x});
  assign ys = $signed({1'b0, y});
  assign lin[0] = lin0; assign lin[1] = lin1; assign lin[2] = lin2;
  assign off[0] = off0; assign off[1] = off1; assign off[2] = off2;

  // stage 1: six 32x13 products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p_r[2*r]   <= P'($signed(lin[r][31:0]) * xs);
        p_r[2*r+1] <= P'($signed(lin[r][63:32]) * ys);
        o_r[r]     <= W'($signed(off[r]));
      end
    end
  end

  // stage 2: three-term sums
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= W'(p_r[0]) + W'(p_r[1]) + o_r[0];
      sy <= W'(p_r[2]) + W'(p_r[3]) + o_r[1];
      sw <= W'(p_r[4]) + W'(p_r[5]) + o_r[2];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/projective_pixel_warp.sv
// Top level of the projective pixel warp: config registers, row math, divider chain.
// Usage:
//   Input channel in_valid/in_stall carries src_x, src_y and pixel_in; the output
//   channel out_valid/out_stall carries dest_x, dest_y, pixel_out and
//   write_enable. Items enter one per clock while in_stall is low and leave in order.
//   The pipeline has two multiply/sum stages, a stage forming magnitudes, a row
//   of 50 division cells (one quotient bit each), then a result register.
//   Throughput is one item per clock unless the output stalls.
//   The matrix is programmed over the cfg_ APB port (64-bit data, registers at
//   8-byte steps); the user must do so only while no item is in flight, as the
//   block does not enforce it; canvas sizes above MAX_DIM saturate.
//   Reset loads the identity matrix and a 4096 square canvas and empties the
//   pipeline. An output stall while the result register holds an item freezes
//   the whole pipeline; in_stall is raised only while that untaken item is held.
`timescale 1ns / 1ps
`default_nettype none
module projective_pixel_warp #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [ppw_pkg::COORD_W-1:0]  in_src_x,
  input  wire  [ppw_pkg::COORD_W-1:0]  in_src_y,
  input  wire  [23:0]                  in_pixel_in,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [ppw_pkg::COORD_W-1:0]  out_dest_x,
  output logic [ppw_pkg::COORD_W-1:0]  out_dest_y,
  output logic [23:0]                  out_pixel_out,
  output logic                         out_write_enable,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [ppw_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire  [63:0]                  cfg_pwdata,
  output logic [63:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  localparam int W  = ppw_pkg::SUM_W;
  localparam int DW = ppw_pkg::DIM_W;
  localparam int NCELL = W;
  localparam int PW = (PIXEL_BITS < 24) ? PIXEL_BITS : 24;
  // the register cannot exceed 8191, so larger limits never clip
  localparam logic [DW-1:0] MAXD = DW'(MAX_DIM > 8191 ? 8191 : MAX_DIM);

  logic [63:0] lin0_r, lin1_r, lin2_r;
  logic [ppw_pkg::OFFS_W-1:0] off0_r, off1_r, off2_r;
  logic [DW-1:0] cw_r, ch_r;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin0_r <= 64'd65536; off0_r <= '0;
      lin1_r <= 64'd281474976710656; off1_r <= '0;
      lin2_r <= '0; off2_r <= 48'd65536;
      cw_r <= 13'd4096; ch_r <= 13'd4096;
    end else if (wr) begin
      unique case (cfg_paddr)
        ppw_pkg::REG_ROW0_LIN: lin0_r <= cfg_pwdata;
        ppw_pkg::REG_ROW0_OFF: off0_r <= cfg_pwdata[47:0];
        ppw_pkg::REG_ROW1_LIN: lin1_r <= cfg_pwdata;
        ppw_pkg::REG_ROW1_OFF: off1_r <= cfg_pwdata[47:0];
        ppw_pkg::REG_ROW2_LIN: lin2_r <= cfg_pwdata;
        ppw_pkg::REG_ROW2_OFF: off2_r <= cfg_pwdata[47:0];
        ppw_pkg::REG_CANVAS_W: cw_r <= cfg_pwdata[DW-1:0];
        ppw_pkg::REG_CANVAS_H: ch_r <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ppw_pkg::REG_ROW0_LIN: cfg_prdata = lin0_r;
      ppw_pkg::REG_ROW0_OFF: cfg_prdata = {16'd0, off0_r};
      ppw_pkg::REG_ROW1_LIN: cfg_prdata = lin1_r;
      ppw_pkg::REG_ROW1_OFF: cfg_prdata = {16'd0, off1_r};
      ppw_pkg::REG_ROW2_LIN: cfg_prdata = lin2_r;
      ppw_pkg::REG_ROW2_OFF: cfg_prdata = {16'd0, off2_r};
      ppw_pkg::REG_CANVAS_W: cfg_prdata = {51'd0, cw_r};
      ppw_pkg::REG_CANVAS_H: cfg_prdata = {51'd0, ch_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // global advance: pipeline moves unless the output holds an untaken item
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front stages: valid and pixel shadow the row evaluator
  logic [1:0] fv_r;
  logic [PW-1:0] fp_r [2];
  logic signed [W-1:0] sx, sy, sw;

  ppw_row_eval u_row (
    .clk(clk), .adv(adv),
    .lin0(lin0_r), .lin1(lin1_r), .lin2(lin2_r),
    .off0(off0_r), .off1(off1_r), .off2(off2_r),
    .x(in_src_x), .y(in_src_y),
    .sx(sx), .sy(sy), .sw(sw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[0], in_valid};
    end
    if (adv) begin
      fp_r[0] <= in_pixel_in[PW-1:0];
      fp_r[1] <= fp_r[0];
    end
  end

  // magnitude stage feeding the cell row
  ppw_pkg::div_lane_t lx [NCELL+1];
  ppw_pkg::div_lane_t ly [NCELL+1];
  ppw_pkg::div_ctl_t  lc [NCELL+1];
  logic [PW-1:0]      lp [NCELL+1];
  ppw_pkg::div_lane_t mx_r, my_r;
  ppw_pkg::div_ctl_t  mc_r;
  logic [PW-1:0]      mp_r;
  logic [DW-1:0] cwl, chl;

  assign cwl = (cw_r > MAXD) ? MAXD : cw_r;
  assign chl = (ch_r > MAXD) ? MAXD : ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mx_r.vld <= 1'b0;
    end else if (adv) begin
      mx_r.vld <= fv_r[1];
    end
    if (adv) begin
      mx_r.neg <= sx[W-1] ^ sw[W-1];
      mx_r.rem <= '0;
      mx_r.quo <= sx[W-1] ? W'(-sx) : sx;
      my_r.vld <= 1'b0;
      my_r.neg <= sy[W-1] ^ sw[W-1];
      my_r.rem <= '0;
      my_r.quo <= sy[W-1] ? W'(-sy) : sy;
      mc_r.dmag <= sw[W-1] ? W'(-sw) : sw;
      mc_r.wz   <= (sw == '0);
      mc_r.cw   <= cwl;
      mc_r.ch   <= chl;
      mp_r      <= fp_r[1];
    end
  end

  assign lx[0] = mx_r;
  assign ly[0] = my_r;
  assign lc[0] = mc_r;
  assign lp[0] = mp_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ppw_div_cell #(.PIX_W(PW)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .x_i(lx[k]), .y_i(ly[k]), .ctl_i(lc[k]), .pix_i(lp[k]),
      .x_o(lx[k+1]), .y_o(ly[k+1]), .ctl_o(lc[k+1]), .pix_o(lp[k+1])
    );
  end

  // sign fix, canvas check and output register
  ppw_pkg::div_lane_t fx, fy;
  ppw_pkg::div_ctl_t  fc;
  logic [W-1:0] qx_mag, qy_mag;
  logic okx, oky, we;
  assign fx = lx[NCELL];
  assign fy = ly[NCELL];
  assign fc = lc[NCELL];
  assign qx_mag = fx.quo;
  assign qy_mag = fy.quo;
  // a negative quotient is inside only when it truncates to zero
  assign okx = (qx_mag == '0) || (!fx.neg && qx_mag < W'(fc.cw));
  assign oky = (qy_mag == '0) || (!fy.neg && qy_mag < W'(fc.ch));
  assign we  = !fc.wz && okx && oky && (fc.cw != '0) && (fc.ch != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fx.vld;
    end
    if (adv) begin
      out_dest_x       <= we ? qx_mag[ppw_pkg::COORD_W-1:0] : '0;
      out_dest_y       <= we ? qy_mag[ppw_pkg::COORD_W-1:0] : '0;
      out_pixel_out    <= 24'(lp[NCELL]);
      out_write_enable <= we;
    end
  end

  // assertions
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dest_x) && $stable(out_write_enable))
    else $error("result changed while stalled");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_we_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_dest_x == '0 && out_dest_y == '0)
    else $error("coordinates not cleared on rejected item");
  a_wz: assert property (@(posedge clk) disable iff (!rst_n)
    adv && fx.vld && fc.wz |=> !out_write_enable)
    else $error("write enabled with zero W");
endmodule
`default_nettype wire

>>> tb/ppw_checker.sv
// Checker for the projective pixel warp: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module ppw_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [11:0] in_src_x,
  input  wire  [11:0] in_src_y,
  input  wire  [23:0] in_pixel_in,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [11:0] out_dest_x,
  input  wire  [11:0] out_dest_y,
  input  wire  [23:0] out_pixel_out,
  input  wire         out_write_enable,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire         cfg_pready,
  input  wire  [5:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [11:0] dx;
    logic [11:0] dy;
    logic [23:0] pix;
    logic        we;
  } warp_result_t;

  // shadow copy of the matrix and canvas
  logic [63:0] lin [3];
  logic signed [47:0] offs [3];
  logic [12:0] cw, ch;
  warp_result_t warp_queue[$];

  function automatic longint clamp_dim(logic [12:0] v);
    return (v > 13'd4096) ? 4096 : longint'(v);
  endfunction

  function automatic longint row_sum(int r, longint x, longint y);
    longint p, q;
    p = longint'($signed(lin[r][31:0]));
    q = longint'($signed(lin[r][63:32]));
    return p * x + q * y + longint'(offs[r]);
  endfunction

  function automatic warp_result_t warp_pixel(logic [11:0] sx, logic [11:0] sy,
                                              logic [23:0] pix);
    warp_result_t res;
    longint x, y, bx, by, bw, qx, qy;
    x = longint'(sx);
    y = longint'(sy);
    bx = row_sum(0, x, y);
    by = row_sum(1, x, y);
    bw = row_sum(2, x, y);
    res = '0;
    res.pix = pix;
    if (bw != 0) begin
      qx = bx / bw;
      qy = by / bw;
      if (qx >= 0 && qx < clamp_dim(cw) && qy >= 0 && qy < clamp_dim(ch)) begin
        res.dx = qx[11:0];
        res.dy = qy[11:0];
        res.we = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    warp_result_t got, exp_r;
    if (!rst_n) begin
      lin[0] <= 64'd65536;
      lin[1] <= 64'd281474976710656;
      lin[2] <= 64'd0;
      offs[0] <= '0;
      offs[1] <= '0;
      offs[2] <= 48'sd65536;
      cw <= 13'd4096;
      ch <= 13'd4096;
      fail_count <= 0;
      pending <= 0;
      warp_queue.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ppw_pkg::REG_ROW0_LIN: lin[0] <= cfg_pwdata;
          ppw_pkg::REG_ROW0_OFF: offs[0] <= cfg_pwdata[47:0];
          ppw_pkg::REG_ROW1_LIN: lin[1] <= cfg_pwdata;
          ppw_pkg::REG_ROW1_OFF: offs[1] <= cfg_pwdata[47:0];
          ppw_pkg::REG_ROW2_LIN: lin[2] <= cfg_pwdata;
          ppw_pkg::REG_ROW2_OFF: offs[2] <= cfg_pwdata[47:0];
          ppw_pkg::REG_CANVAS_W: cw <= cfg_pwdata[12:0];
          ppw_pkg::REG_CANVAS_H: ch <= cfg_pwdata[12:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && !in_stall)
        warp_queue.push_back(warp_pixel(in_src_x, in_src_y, in_pixel_in));
      // accepted result item
      if (out_valid && !out_stall) begin
        got = {out_dest_x, out_dest_y, out_pixel_out, out_write_enable};
        if (warp_queue.size() == 0) begin
          $display("%0t: unexpected item, expected none, got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = warp_queue.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch x/y/pix/we expected %h %h %h %b, got %h %h %h %b",
                     $time, exp_r.dx, exp_r.dy, exp_r.pix, exp_r.we,
                     got.dx, got.dy, got.pix, got.we);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= warp_queue.size();
    end
  end
endmodule

>>> tb/tb_top.sv
// Testbench top for the projective pixel warp: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
  localparam int LATENCY = 54;
  localparam int WATCHDOG = 2000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [11:0] in_src_x, in_src_y, out_dest_x, out_dest_y;
  logic [23:0] in_pixel_in, out_pixel_out;
  logic out_write_enable;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending, idle_cycles;
  bit stall_free;

  projective_pixel_warp DUT (.*);

  ppw_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver stall pattern: a fresh random wait, possibly none, before every result item
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = stall_free ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic cfg_write(logic [5:0] addr, logic [63:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [31:0] ma, logic [31:0] mb, logic [47:0] mc,
                             logic [31:0] md, logic [31:0] me, logic [47:0] mf,
                             logic [31:0] mg, logic [31:0] mh, logic [47:0] mi,
                             logic [12:0] w, logic [12:0] h);
    cfg_write(ppw_pkg::REG_ROW0_LIN, {mb, ma});
    cfg_write(ppw_pkg::REG_ROW0_OFF, {16'd0, mc});
    cfg_write(ppw_pkg::REG_ROW1_LIN, {me, md});
    cfg_write(ppw_pkg::REG_ROW1_OFF, {16'd0, mf});
    cfg_write(ppw_pkg::REG_ROW2_LIN, {mh, mg});
    cfg_write(ppw_pkg::REG_ROW2_OFF, {16'd0, mi});
    cfg_write(ppw_pkg::REG_CANVAS_W, {51'd0, w});
    cfg_write(ppw_pkg::REG_CANVAS_H, {51'd0, h});
  endtask

  // drain in-flight items before touching registers
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // send one pixel, holding it until accepted
  task automatic send_pixel(logic [11:0] sx, logic [11:0] sy, logic [23:0] pix,
                            bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_x <= sx;
    in_src_y <= sy;
    in_pixel_in <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    bit burst;
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      stall_free = burst;
      send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 24'($urandom), burst);
    end
    in_valid <= 1'b0;
    stall_free = 1'b0;
  endtask

  function automatic logic [31:0] rnd_coef(int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return 32'(v);
  endfunction

  initial begin
    logic [31:0] ga, gb, gd, ge, gg, gh;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_src_x = '0;
    in_src_y = '0;
    in_pixel_in = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    stall_free = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity at reset, field extremes
    send_pixel(12'd0, 12'd0, 24'h000000, 1'b0);
    send_pixel(12'd4095, 12'd4095, 24'hFFFFFF, 1'b0);
    send_pixel(12'd4095, 12'd0, 24'hA5A5A5, 1'b1);
    send_pixel(12'd0, 12'd4095, 24'h5A5A5A, 1'b1);
    in_valid <= 1'b0;
    drain();

    // W is zero everywhere
    load_matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 13'd4096, 13'd4096);
    send_pixel(12'd10, 12'd20, 24'h123456, 1'b0);
    send_pixel(12'd0, 12'd0, 24'h654321, 1'b0);
    in_valid <= 1'b0;
    drain();

    // negative W, negative numerators; canvas saturates above max, then zero canvas
    load_matrix(-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0, -48'sh10000,
                13'd8191, 13'd5000);
    send_pixel(12'd100, 12'd200, 24'h111111, 1'b0);
    send_pixel(12'd4095, 12'd4095, 24'h222222, 1'b0);
    in_valid <= 1'b0;
    drain();
    load_matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 48'h10000, 13'd0, 13'd0);
    send_pixel(12'd0, 12'd0, 24'h333333, 1'b0);
    send_pixel(12'd5, 12'd5, 24'h444444, 1'b0);
    in_valid <= 1'b0;
    drain();

    // extreme coefficients: largest sums, divisor at full magnitude
    load_matrix(32'h7FFFFFFF, 32'h80000000, 48'h7FFFFFFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 48'h800000000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 48'h7FFFFFFFFFFF, 13'd1, 13'd1);
    send_pixel(12'd4095, 12'd4095, 24'hFFFFFF, 1'b0);
    send_pixel(12'd1, 12'd0, 24'h000001, 1'b0);
    in_valid <= 1'b0;
    drain();

    // random phases: mostly near-identity warps so many pixels land inside
    for (int ph = 0; ph < 8; ph++) begin
      ga = 32'h10000 + rnd_coef(16384); gb = rnd_coef(8192);
      gd = rnd_coef(8192); ge = 32'h10000 + rnd_coef(16384);
      gg = (ph % 3 == 0) ? rnd_coef(8) : 32'd0;
      gh = (ph % 3 == 0) ? rnd_coef(8) : 32'd0;
      if (ph == 7)
        load_matrix($urandom, $urandom, 48'({$urandom, $urandom}),
                    $urandom, $urandom, 48'({$urandom, $urandom}),
                    $urandom, $urandom, 48'({$urandom, $urandom}),
                    13'($urandom), 13'($urandom));
      else
        load_matrix(ga, gb, 48'(longint'($signed(rnd_coef(65536))) * 1024), gd, ge,
                    48'(longint'($signed(rnd_coef(65536))) * 1024), gg, gh,
                    48'(longint'($urandom_range(32768, 131072))),
                    13'($urandom_range(1, 4600)), 13'($urandom_range(1, 4600)));
      random_phase(212);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
